// ===== design/hesc_pkg.sv =====
package hesc_pkg;

  localparam int unsigned EVENT_W          = 32;
  localparam int unsigned POWER_BUTTON_BIT = 11;
  localparam int unsigned EVENT_NUM_W      = 6;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 32;

  // wake never follows the power button event
  localparam logic [EVENT_W-1:0] WAKE_KEEP = ~(EVENT_W'(1) << POWER_BUTTON_BIT);

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_QUERY = 1'b1
  } hesc_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMI_MASK   = 2'd0,
    CFG_SCI_MASK   = 2'd1,
    CFG_WAKE_MASK  = 2'd2,
    CFG_LINK_READY = 2'd3
  } hesc_cfg_idx_e;

  typedef struct packed {
    logic [EVENT_W-1:0] smi_mask;
    logic [EVENT_W-1:0] sci_mask;
    logic [EVENT_W-1:0] wake_mask;
    logic               link_ready;
  } hesc_cfg_t;

  // packed so that smi_pulse lands in bit 0
  typedef struct packed {
    logic [EVENT_W-1:0]     events_now;
    logic [EVENT_NUM_W-1:0] event_number;
    logic                   sci_flag;
    logic                   smi_flag;
    logic                   wake_asserted;
    logic                   sci_pulse;
    logic                   smi_pulse;
  } hesc_result_t;

  localparam int unsigned RESULT_W = $bits(hesc_result_t);
  localparam int unsigned M_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== design/host_event_sci_smi_controller.sv =====
// Host event controller: keeps the pending host event set and drives SMI, SCI and
// wake from it. Each request (set or query) gives exactly one result transfer. An
// item passes through an input register and a result register, and one item is
// accepted every cycle while the result side does not stall; the event state is
// updated as an item moves into the result register, so the next item already
// sees it. Configuration writes take effect at the next edge and should only be
// made while no request is in flight.
module host_event_sci_smi_controller import hesc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [EVENT_W-1:0]    s_axis_tdata_i,   // event_bits
  input  logic                  s_axis_tuser_i,   // req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // smi_pulse, sci_pulse, wake_asserted, smi_flag, sci_flag, event_number,
  // events_now, zero fill
  output logic [M_DATA_W-1:0]   m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  hesc_cfg_t          cfg_q;
  logic               in_valid_q;
  logic               in_req_q;
  logic [EVENT_W-1:0] in_bits_q;
  logic               out_valid_q;
  hesc_result_t       result_q;
  hesc_result_t       result_d;
  logic               load_out;
  logic               in_ready;

  assign load_out = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign in_ready = !in_valid_q || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (hesc_cfg_idx_e'(cfg_idx_i))
        CFG_SMI_MASK:   cfg_q.smi_mask   <= cfg_wdata_i[EVENT_W-1:0];
        CFG_SCI_MASK:   cfg_q.sci_mask   <= cfg_wdata_i[EVENT_W-1:0];
        CFG_WAKE_MASK:  cfg_q.wake_mask  <= cfg_wdata_i[EVENT_W-1:0];
        CFG_LINK_READY: cfg_q.link_ready <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && in_ready) begin
      in_req_q  <= s_axis_tuser_i;
      in_bits_q <= s_axis_tdata_i;
    end
    if (load_out) begin
      result_q <= result_d;
    end
  end

  hesc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (load_out),
    .req_type_i   (in_req_q),
    .event_bits_i (in_bits_q),
    .cfg_i        (cfg_q),
    .result_o     (result_d)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_DATA_W - RESULT_W)'(0), result_q};

endmodule

// ===== design/hesc_core.sv =====
module hesc_core import hesc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               req_type_i,
  input  logic [EVENT_W-1:0] event_bits_i,
  input  hesc_cfg_t          cfg_i,
  output hesc_result_t       result_o
);

  logic [EVENT_W-1:0]     pending_q, pending_d;
  logic                   smi_pending_q, smi_pending_d;
  logic                   sci_pending_q, sci_pending_d;
  logic                   wake_q, wake_d;
  logic [EVENT_W-1:0]     watch_mask, hit, hit_lsb, scan_mask, cleared;
  logic [EVENT_NUM_W-1:0] hit_number, answer;
  logic                   update, smi_hit, sci_hit, wake_hit;

  function automatic logic [EVENT_NUM_W-1:0] onehot_number(input logic [EVENT_W-1:0] oh);
    logic [EVENT_NUM_W-1:0] num;
    num = '0;
    for (int i = 0; i < EVENT_W; i++) begin
      if (oh[i]) begin
        num = num | EVENT_NUM_W'(i + 1);
      end
    end
    return num;
  endfunction

  // query clears every pending bit up to and including the first masked one (all of them if none is masked)
  assign watch_mask = cfg_i.smi_mask | cfg_i.sci_mask | cfg_i.wake_mask;
  assign hit        = pending_q & watch_mask;
  assign hit_lsb    = hit & (~hit + EVENT_W'(1));
  assign scan_mask  = hit ^ (hit - EVENT_W'(1));
  assign cleared    = pending_q & ~scan_mask;
  assign hit_number = onehot_number(hit_lsb);

  always_comb begin
    if (hesc_req_e'(req_type_i) == REQ_SET) begin
      pending_d = event_bits_i;
      answer    = '0;
    end else begin
      pending_d = cleared;
      answer    = hit_number;
    end
  end

  assign update   = (pending_d != pending_q) && cfg_i.link_ready;
  assign smi_hit  = |(pending_d & cfg_i.smi_mask);
  assign sci_hit  = |(pending_d & cfg_i.sci_mask);
  assign wake_hit = |(pending_d & cfg_i.wake_mask & WAKE_KEEP);

  assign smi_pending_d = update ? smi_hit : smi_pending_q;
  assign sci_pending_d = update ? sci_hit : sci_pending_q;
  assign wake_d        = update ? wake_hit : wake_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      smi_pending_q <= 1'b0;
      sci_pending_q <= 1'b0;
      wake_q        <= 1'b0;
    end else if (advance_i) begin
      pending_q     <= pending_d;
      smi_pending_q <= smi_pending_d;
      sci_pending_q <= sci_pending_d;
      wake_q        <= wake_d;
    end
  end

  always_comb begin
    result_o.smi_pulse     = update && smi_hit && !smi_pending_q;
    result_o.sci_pulse     = update && sci_hit;
    result_o.wake_asserted = wake_d;
    result_o.smi_flag      = smi_pending_d;
    result_o.sci_flag      = sci_pending_d;
    result_o.event_number  = answer;
    result_o.events_now    = pending_d;
  end

endmodule

// ===== design/hesc_checker.sv =====
module hesc_checker import hesc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [M_DATA_W-1:0]   m_axis_tdata_o
);

  hesc_result_t res;
  assign res = m_axis_tdata_o[RESULT_W-1:0];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_smi_pulse_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.smi_pulse |-> res.smi_flag)
    else $error("smi pulse without smi flag");

  a_sci_pulse_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.sci_pulse |-> res.sci_flag)
    else $error("sci pulse without sci flag");

  a_number_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res.event_number <= EVENT_NUM_W'(EVENT_W))
    else $error("event number out of range");

  // the answered event has been cleared from the set
  a_answer_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.event_number != '0
      |-> (res.events_now & (EVENT_W'(1) << (res.event_number - EVENT_NUM_W'(1)))) == '0)
    else $error("answered event still pending");

endmodule

bind host_event_sci_smi_controller hesc_checker u_hesc_checker (.*);

// ===== test/hesc_checker.sv =====
`timescale 1ns / 1ps

module hesc_tb_checker import hesc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [EVENT_W-1:0]    s_tdata_i,   // event_bits
  input  logic                  s_tuser_i,   // req_type
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  // smi_pulse, sci_pulse, wake_asserted, smi_flag, sci_flag, event_number,
  // events_now, zero fill
  input  logic [M_DATA_W-1:0]   m_tdata_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    err_count_o,
  output int                    exp_left_o
);

  logic [EVENT_W-1:0] smi_mask, sci_mask, wake_mask;
  logic               link_up;
  logic [EVENT_W-1:0] events_q;
  logic               smi_pend, sci_pend, wake_lvl;
  hesc_result_t       status_q[$];
  int                 errs;

  assign err_count_o = errs;

  function automatic hesc_result_t predict_status(input hesc_req_e req,
                                                  input logic [EVENT_W-1:0] bits);
    hesc_result_t       r;
    logic [EVENT_W-1:0] watched, prior;
    logic               hit;
    r = '0;
    prior = events_q;
    if (req == REQ_SET) begin
      events_q = bits;
    end else begin
      watched = smi_mask | sci_mask | wake_mask;
      for (int i = 0; i < EVENT_W; i++) begin
        if (events_q[i]) begin
          events_q[i] = 1'b0;
          if (watched[i]) begin
            r.event_number = EVENT_NUM_W'(i + 1);
            break;
          end
        end
      end
    end
    if (events_q != prior && link_up) begin
      hit = |(events_q & smi_mask);
      r.smi_pulse = hit & ~smi_pend;
      smi_pend = hit;
      sci_pend = |(events_q & sci_mask);
      r.sci_pulse = sci_pend;
      wake_lvl = |(events_q & wake_mask & ~(EVENT_W'(1) << POWER_BUTTON_BIT));
    end
    r.wake_asserted = wake_lvl;
    r.smi_flag = smi_pend;
    r.sci_flag = sci_pend;
    r.events_now = events_q;
    return r;
  endfunction

  function automatic int check_field(input string name, input logic [EVENT_W-1:0] want,
                                     input logic [EVENT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hesc_result_t want, got;
    if (!rst_ni) begin
      smi_mask = '0;
      sci_mask = '0;
      wake_mask = '0;
      link_up = 1'b0;
      events_q = '0;
      smi_pend = 1'b0;
      sci_pend = 1'b0;
      wake_lvl = 1'b0;
      status_q.delete();
      errs = 0;
      exp_left_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = hesc_result_t'(m_tdata_i[RESULT_W-1:0]);
        if (status_q.size() == 0) begin
          $display("%0t: result with no request waiting, expected none actual %0h",
                   $time, got);
          errs++;
        end else begin
          want = status_q.pop_front();
          errs += check_field("smi_pulse", EVENT_W'(want.smi_pulse),
                              EVENT_W'(got.smi_pulse));
          errs += check_field("sci_pulse", EVENT_W'(want.sci_pulse),
                              EVENT_W'(got.sci_pulse));
          errs += check_field("wake_asserted", EVENT_W'(want.wake_asserted),
                              EVENT_W'(got.wake_asserted));
          errs += check_field("smi_flag", EVENT_W'(want.smi_flag),
                              EVENT_W'(got.smi_flag));
          errs += check_field("sci_flag", EVENT_W'(want.sci_flag),
                              EVENT_W'(got.sci_flag));
          errs += check_field("event_number", EVENT_W'(want.event_number),
                              EVENT_W'(got.event_number));
          errs += check_field("events_now", want.events_now, got.events_now);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        status_q.push_back(predict_status(hesc_req_e'(s_tuser_i), s_tdata_i));
      end
      if (cfg_we_i) begin
        case (hesc_cfg_idx_e'(cfg_idx_i))
          CFG_SMI_MASK:   smi_mask = cfg_wdata_i;
          CFG_SCI_MASK:   sci_mask = cfg_wdata_i;
          CFG_WAKE_MASK:  wake_mask = cfg_wdata_i;
          CFG_LINK_READY: link_up = cfg_wdata_i[0];
          default: ;
        endcase
      end
      exp_left_o <= status_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hesc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 110;
  localparam int PHASES         = 8;
  localparam int HOLD_CYCLES    = 60;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [EVENT_W-1:0]    s_axis_tdata = '0;   // event_bits
  logic                  s_axis_tuser = 1'b0; // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // smi_pulse, sci_pulse, wake_asserted, smi_flag, sci_flag, event_number,
  // events_now, zero fill
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int                 fail_count, left_count;
  int                 quiet_cycles = 0;
  bit                 idle_en = 1'b1;
  bit                 press_go = 1'b0;
  bit                 press_done = 1'b0;
  logic [EVENT_W-1:0] last_bits = '0;

  host_event_sci_smi_controller u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  hesc_tb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .err_count_o (fail_count),
    .exp_left_o  (left_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL host_event_sci_smi_controller");
      $finish;
    end
  end

  // result side
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (press_go && !press_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        press_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input hesc_req_e req, input logic [EVENT_W-1:0] bits);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (left_count != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input hesc_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [EVENT_W-1:0] smi, input logic [EVENT_W-1:0] sci,
                            input logic [EVENT_W-1:0] wake, input logic link);
    drain();
    cfg_write(CFG_SMI_MASK, smi);
    cfg_write(CFG_SCI_MASK, sci);
    cfg_write(CFG_WAKE_MASK, wake);
    cfg_write(CFG_LINK_READY, CFG_DATA_W'(link));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [EVENT_W-1:0] pick_events();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return EVENT_W'(1) << $urandom_range(0, EVENT_W - 1);
      2:       return $urandom & $urandom & $urandom;
      3:       return last_bits;
      4:       return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom | (EVENT_W'(1) << POWER_BUTTON_BIT);
    endcase
  endfunction

  function automatic logic [EVENT_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      3:       return $urandom & $urandom;
      4:       return EVENT_W'(1) << $urandom_range(0, EVENT_W - 1);
      default: return EVENT_W'(1) << POWER_BUTTON_BIT;
    endcase
  endfunction

  initial begin
    logic [EVENT_W-1:0] bits;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // link down, no masks
    send_item(REQ_SET, '1);
    send_item(REQ_QUERY, $urandom);

    set_config(32'h0000_0001, 32'h8000_0000, 32'h0000_0802, 1'b1);
    send_item(REQ_SET, 32'h0000_0800);
    send_item(REQ_SET, 32'h0000_0801);
    send_item(REQ_SET, 32'h0000_0801);
    send_item(REQ_SET, 32'h0000_0803);
    send_item(REQ_SET, 32'h8000_0803);
    repeat (5) send_item(REQ_QUERY, $urandom);
    send_item(REQ_SET, 32'h0000_F000);
    send_item(REQ_QUERY, $urandom);
    send_item(REQ_SET, '1);
    send_item(REQ_SET, '0);

    set_config('1, '1, '1, 1'b1);
    send_item(REQ_SET, '1);
    send_item(REQ_QUERY, $urandom);
    send_item(REQ_QUERY, $urandom);
    send_item(REQ_SET, 32'h8000_0000);
    send_item(REQ_QUERY, $urandom);

    // link down again, flags held
    set_config(32'h1, 32'h1, 32'h1, 1'b0);
    send_item(REQ_SET, 32'h0000_0001);
    send_item(REQ_QUERY, $urandom);
    send_item(REQ_SET, '1);

    for (int p = 0; p < PHASES; p++) begin
      idle_en = (p < PHASES - 1);
      case (p)
        0:       set_config('1, '1, '1, 1'b1);
        1:       set_config('0, '0, '0, 1'b1);
        default: set_config(pick_mask(), pick_mask(), pick_mask(), $urandom_range(0, 4) != 0);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 20) press_go = 1'b1;
        if ($urandom_range(0, 9) < 4) begin
          send_item(REQ_QUERY, $urandom);
        end else begin
          bits = pick_events();
          last_bits = bits;
          send_item(REQ_SET, bits);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && left_count == 0) begin
      $display("PASS host_event_sci_smi_controller");
    end else begin
      $display("FAIL host_event_sci_smi_controller");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hesc_pkg.sv
design/hesc_core.sv
design/host_event_sci_smi_controller.sv
design/hesc_checker.sv
test/hesc_checker.sv
test/tb_top.sv
